>>> src/kmd_pkg.sv
package kmd_pkg;

    localparam int ROW_W   = 3;
    localparam int LEVEL_W = 14;
    localparam int TIME_W  = 32;
    localparam int DMS_W   = 16;

    localparam logic [DMS_W-1:0] DEBOUNCE_RESET = 16'd5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int INFL_W     = 2;

    typedef struct packed {
        logic [ROW_W-1:0]   row_out;
        logic [LEVEL_W-1:0] debounced_cols;
        logic [LEVEL_W-1:0] committed_cols;
    } t_out_item;

endpackage

>>> src/kmd_if.sv
interface kmd_in_if import kmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] col_levels;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output row, output col_levels, output now_ms, input ready);
    modport sink   (input valid, input row, input col_levels, input now_ms, output ready);
endinterface

interface kmd_out_if import kmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_out;
    logic [LEVEL_W-1:0] debounced_cols;
    logic [LEVEL_W-1:0] committed_cols;

    modport source (output valid, output row_out, output debounced_cols,
                    output committed_cols, input ready);
    modport sink   (input valid, input row_out, input debounced_cols,
                    input committed_cols, output ready);
endinterface

interface kmd_cfg_if import kmd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DMS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/key_matrix_debouncer.sv
// Per-key debouncer for a scanned key matrix. Each input beat is one scanned row (row, active-low
// column levels, millisecond time); each output beat gives that row's debounced pressed bits and
// the bits committed by this scan. The block takes one row per cycle while queue credit remains;
// a result passes the read and update stages and then the result queue before it is offered.
// The rate is set by the per-row read-modify-write of the timer memory (one row of COLS 32-bit
// timers per entry), which runs as read and update stages with the last write-back forwarded
// to the next row beats. Results wait in a four-entry queue; input ready drops while queued plus
// in-flight rows reach four. Timer rows and debounced rows are cleared at reset through per-row
// valid bits and flops, so there is no clearing pass. The debounce interval is written on the
// configuration channel (reset value 5 ms) and must only change while the block is idle.
module key_matrix_debouncer import kmd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmd_in_if.sink    i_in,
    kmd_cfg_if.sink   i_cfg,
    kmd_out_if.source o_out
);

    logic [DMS_W-1:0]      r_debounce_ms;
    logic                  w_accept;
    logic                  w_push;
    t_out_item             w_item;
    logic [INFL_W-1:0]     w_inflight;
    logic [FIFO_CNT_W-1:0] w_fifo_count;
    logic [FIFO_CNT_W-1:0] w_credit_used;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_debounce_ms <= i_cfg.data;
        end
    end

    // hold input while every queue slot is spoken for
    assign w_credit_used = w_fifo_count + FIFO_CNT_W'(w_inflight);
    assign i_in.ready    = (w_credit_used < FIFO_CNT_W'(FIFO_DEPTH));
    assign w_accept      = i_in.valid && i_in.ready;

    kmd_row_pipe #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (w_accept),
        .i_row         (i_in.row),
        .i_levels      (i_in.col_levels),
        .i_now         (i_in.now_ms),
        .i_debounce_ms (r_debounce_ms),
        .o_push        (w_push),
        .o_item        (w_item),
        .o_inflight    (w_inflight)
    );

    kmd_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_count (w_fifo_count),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fifo_count < FIFO_CNT_W'(FIFO_DEPTH)) || (o_out.valid && o_out.ready))
        else $error("result queue overflow");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit_used <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("in-flight rows exceed queue space");

    a_accept_reaches_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 w_push)
        else $error("accepted row beat did not reach the queue");

    a_out_of_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (5'(o_out.row_out) >= 5'(ROWS)))
            |-> (o_out.committed_cols == '0) && (o_out.debounced_cols == '0))
        else $error("out-of-range row reported keys");

endmodule

>>> src/kmd_row_pipe.sv
module kmd_row_pipe import kmd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [LEVEL_W-1:0] i_levels,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [DMS_W-1:0]   i_debounce_ms,
    output logic               o_push,
    output t_out_item          o_item,
    output logic [INFL_W-1:0]  o_inflight
);

    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TW  = COLS * TIME_W;
    localparam int XW  = RW + ROW_W;

    // timer memory, one row of COLS timers per entry, plus row valid bits
    logic [TW-1:0]   r_tm_mem [ROWS];
    logic [ROWS-1:0] r_tm_vld;
    logic [COLS-1:0] r_deb [ROWS];

    logic [XW-1:0] w_row_ext;
    logic          w_in_range;
    logic [RW-1:0] w_row_idx;

    assign w_row_ext  = XW'(i_row);
    assign w_in_range = (w_row_ext < XW'(ROWS));
    assign w_row_idx  = w_row_ext[RW-1:0];

    // stage 1: read
    logic               r_s1_vld;
    logic               r_s1_inr;
    logic [ROW_W-1:0]   r_s1_row;
    logic [RW-1:0]      r_s1_idx;
    logic [LEVEL_W-1:0] r_s1_lev;
    logic [TIME_W-1:0]  r_s1_now;
    logic [TW-1:0]      r_s1_tm;
    logic               r_s1_tmv;
    logic [COLS-1:0]    r_s1_deb;

    // stage 2: update
    logic               r_s2_vld;
    logic               r_s2_inr;
    logic [ROW_W-1:0]   r_s2_row;
    logic [RW-1:0]      r_s2_idx;
    logic [COLS-1:0]    r_s2_raw;
    logic [TIME_W-1:0]  r_s2_now;
    logic [TW-1:0]      r_s2_tm;
    logic [COLS-1:0]    r_s2_deb;

    // last write-back, kept for forwarding
    logic               r_wb_vld;
    logic [RW-1:0]      r_wb_idx;
    logic [TW-1:0]      r_wb_tm;
    logic [COLS-1:0]    r_wb_deb;

    logic [TW-1:0]      n_s2_tm;
    logic [COLS-1:0]    n_s2_deb;
    logic [COLS-1:0]    n_s2_raw;
    logic               w_s1_hit;
    logic [COLS+LEVEL_W-1:0] w_lev_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_s1_inr <= w_in_range;
            r_s1_row <= i_row;
            r_s1_idx <= w_row_idx;
            r_s1_lev <= i_levels;
            r_s1_now <= i_now;
            r_s1_tm  <= r_tm_mem[w_row_idx];
            r_s1_tmv <= r_tm_vld[w_row_idx];
            r_s1_deb <= r_deb[w_row_idx];
        end
    end

    // pick up the write that landed on the same edge as the read
    assign w_s1_hit  = r_wb_vld && (r_wb_idx == r_s1_idx);
    assign w_lev_ext = (COLS+LEVEL_W)'(r_s1_lev);

    always_comb begin
        n_s2_tm  = w_s1_hit ? r_wb_tm  : (r_s1_tmv ? r_s1_tm : '0);
        n_s2_deb = w_s1_hit ? r_wb_deb : r_s1_deb;
        // columns beyond the input field read low, so pressed
        n_s2_raw = ~w_lev_ext[COLS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_inr <= r_s1_inr;
            r_s2_row <= r_s1_row;
            r_s2_idx <= r_s1_idx;
            r_s2_raw <= n_s2_raw;
            r_s2_now <= r_s1_now;
            r_s2_tm  <= n_s2_tm;
            r_s2_deb <= n_s2_deb;
        end
    end

    logic               w_s2_hit;
    logic [TW-1:0]      w_tm_op;
    logic [COLS-1:0]    w_deb_op;
    logic [TW-1:0]      w_new_tm;
    logic [COLS-1:0]    w_new_deb;
    logic [COLS-1:0]    w_commit;
    logic               w_write;

    assign w_s2_hit = r_wb_vld && (r_wb_idx == r_s2_idx);
    assign w_tm_op  = w_s2_hit ? r_wb_tm  : r_s2_tm;
    assign w_deb_op = w_s2_hit ? r_wb_deb : r_s2_deb;
    assign w_write  = r_s2_vld && r_s2_inr;

    always_comb begin
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] diff;
        w_new_tm  = '0;
        w_new_deb = w_deb_op;
        w_commit  = '0;
        for (int c = 0; c < COLS; c++) begin
            t    = w_tm_op[c*TIME_W +: TIME_W];
            diff = r_s2_now - t;
            if (r_s2_raw[c] != w_deb_op[c]) begin
                if (t == '0) begin
                    w_new_tm[c*TIME_W +: TIME_W] = r_s2_now;
                end else if (diff >= TIME_W'(i_debounce_ms)) begin
                    w_new_deb[c] = r_s2_raw[c];
                    w_commit[c]  = 1'b1;
                end else begin
                    w_new_tm[c*TIME_W +: TIME_W] = t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_tm_mem[r_s2_idx] <= w_new_tm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tm_vld <= '0;
            r_wb_vld <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_deb[r] <= '0;
            end
        end else begin
            r_wb_vld <= w_write;
            if (w_write) begin
                r_tm_vld[r_s2_idx] <= 1'b1;
                r_deb[r_s2_idx]    <= w_new_deb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_wb_idx <= r_s2_idx;
            r_wb_tm  <= w_new_tm;
            r_wb_deb <= w_new_deb;
        end
    end

    logic [COLS+LEVEL_W-1:0] w_deb_ext;
    logic [COLS+LEVEL_W-1:0] w_com_ext;

    assign w_deb_ext = (COLS+LEVEL_W)'(w_new_deb);
    assign w_com_ext = (COLS+LEVEL_W)'(w_commit);

    always_comb begin
        o_push                = r_s2_vld;
        o_item.row_out        = r_s2_row;
        o_item.debounced_cols = r_s2_inr ? w_deb_ext[LEVEL_W-1:0] : '0;
        o_item.committed_cols = r_s2_inr ? w_com_ext[LEVEL_W-1:0] : '0;
        o_inflight            = INFL_W'(r_s1_vld) + INFL_W'(r_s2_vld);
    end

endmodule

>>> src/kmd_out_fifo.sv
module kmd_out_fifo import kmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_out_item             i_item,
    output logic [FIFO_CNT_W-1:0] o_count,
    kmd_out_if.source             o_out
);

    t_out_item               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    w_pop;
    t_out_item               w_head;

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_count              = r_count;
    assign o_out.valid          = (r_count != '0);
    assign o_out.row_out        = w_head.row_out;
    assign o_out.debounced_cols = w_head.debounced_cols;
    assign o_out.committed_cols = w_head.committed_cols;

endmodule

>>> dv/key_matrix_debouncer_tb.sv
module key_matrix_debouncer_tb;
    import kmd_pkg::*;

    localparam int NUM_ROWS    = 8;
    localparam int NUM_COLS    = 14;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  now;
    } t_row_scan;

    logic i_clk;
    logic i_rst_n;

    kmd_in_if  in_bus ();
    kmd_out_if out_bus ();
    kmd_cfg_if cfg_bus ();

    key_matrix_debouncer #(
        .ROWS (NUM_ROWS),
        .COLS (NUM_COLS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    t_row_scan  scans_to_send [$];
    t_out_item  expected_rows [$];

    // predictor state
    logic [DMS_W-1:0]   interval_ms;
    logic [LEVEL_W-1:0] stable_keys [NUM_ROWS];
    logic [TIME_W-1:0]  change_since [NUM_ROWS][NUM_COLS];

    // stimulus state
    logic [LEVEL_W-1:0] held_keys [NUM_ROWS];
    logic [TIME_W-1:0]  wall_ms;

    int  gap_pct;
    int  stall_pct;
    int  fail_count;
    int  cycle_count;
    bit  in_taken;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_out_item scan_row_update(logic [ROW_W-1:0] row,
                                                  logic [LEVEL_W-1:0] levels,
                                                  logic [TIME_W-1:0] now);
        t_out_item          res;
        logic [LEVEL_W-1:0] keys;
        logic [LEVEL_W-1:0] flips;
        logic [TIME_W-1:0]  elapsed;
        keys  = stable_keys[row];
        flips = '0;
        for (int c = 0; c < NUM_COLS; c++) begin
            if (~levels[c] != keys[c]) begin
                if (change_since[row][c] == '0) begin
                    change_since[row][c] = now;
                end else begin
                    elapsed = now - change_since[row][c];
                    if (elapsed >= {16'd0, interval_ms}) begin
                        keys[c]             = ~keys[c];
                        flips[c]            = 1'b1;
                        change_since[row][c] = '0;
                    end
                end
            end else begin
                change_since[row][c] = '0;
            end
        end
        stable_keys[row]   = keys;
        res.row_out        = row;
        res.debounced_cols = keys;
        res.committed_cols = flips;
        return res;
    endfunction

    // feed row beats from the queue, holding each until it is taken
    always @(negedge i_clk) begin : row_driver
        t_row_scan s;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (scans_to_send.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                s = scans_to_send.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.row        <= s.row;
                in_bus.col_levels <= s.levels;
                in_bus.now_ms     <= s.now;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
        out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_out_item got;
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        in_taken <= i_rst_n && in_bus.valid && in_bus.ready;
        if (!i_rst_n) begin
            interval_ms = DEBOUNCE_RESET;
            for (int r = 0; r < NUM_ROWS; r++) begin
                stable_keys[r] = '0;
                for (int c = 0; c < NUM_COLS; c++)
                    change_since[r][c] = '0;
            end
        end else begin
            if (cfg_bus.valid && cfg_bus.ready)
                interval_ms = cfg_bus.data;
            if (in_bus.valid && in_bus.ready)
                expected_rows.push_back(scan_row_update(in_bus.row, in_bus.col_levels,
                                                        in_bus.now_ms));
            if (out_bus.valid && out_bus.ready) begin
                got.row_out        = out_bus.row_out;
                got.debounced_cols = out_bus.debounced_cols;
                got.committed_cols = out_bus.committed_cols;
                if (expected_rows.size() == 0) begin
                    $error("unexpected result beat: row_out %0d", got.row_out);
                    fail_count++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.row_out !== want.row_out) begin
                        $error("row_out: expected %0d, got %0d", want.row_out, got.row_out);
                        fail_count++;
                    end
                    if (got.debounced_cols !== want.debounced_cols) begin
                        $error("debounced_cols: expected %h, got %h",
                               want.debounced_cols, got.debounced_cols);
                        fail_count++;
                    end
                    if (got.committed_cols !== want.committed_cols) begin
                        $error("committed_cols: expected %h, got %h",
                               want.committed_cols, got.committed_cols);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic add_scan(int row, int levels, logic [TIME_W-1:0] now);
        t_row_scan s;
        s.row    = row[ROW_W-1:0];
        s.levels = levels[LEVEL_W-1:0];
        s.now    = now;
        scans_to_send.push_back(s);
    endtask

    // settle again after the wait, a beat popped on the same edge may still be in flight
    task automatic wait_drained();
        do begin
            while (scans_to_send.size() > 0 || in_bus.valid || expected_rows.size() > 0)
                @(negedge i_clk);
            repeat (DRAIN_WAIT) @(negedge i_clk);
        end while (scans_to_send.size() > 0 || in_bus.valid || expected_rows.size() > 0);
    endtask

    task automatic write_interval(logic [DMS_W-1:0] value);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly steady keys with occasional bounce and a clock that moves on a
    // scale of the interval; the rest is noise
    task automatic add_random_scans(int count, logic [DMS_W-1:0] dms);
        t_row_scan s;
        wall_ms = $urandom;
        for (int n = 0; n < count; n++) begin
            s.row = ROW_W'($urandom_range(0, NUM_ROWS - 1));
            if ($urandom_range(0, 99) < 10) begin
                s.levels = LEVEL_W'($urandom);
                s.now    = $urandom;
            end else begin
                if ($urandom_range(0, 3) == 0)
                    held_keys[s.row][$urandom_range(0, NUM_COLS - 1)] ^= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    held_keys[s.row] = LEVEL_W'($urandom);
                s.levels = ~held_keys[s.row];
                if ($urandom_range(0, 99) < 15)
                    s.levels[$urandom_range(0, NUM_COLS - 1)] ^= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    wall_ms = wall_ms + $urandom;
                else
                    wall_ms = wall_ms + $urandom_range(0, int'(dms) / 3 + 2);
                s.now = wall_ms;
            end
            scans_to_send.push_back(s);
        end
    endtask

    initial begin : stimulus
        logic [DMS_W-1:0] dms;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.row        = '0;
        in_bus.col_levels = '1;
        in_bus.now_ms     = '0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = '0;
        gap_pct           = 0;
        stall_pct         = 0;
        fail_count        = 0;
        cycle_count       = 0;
        for (int r = 0; r < NUM_ROWS; r++)
            held_keys[r] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset interval of 5 ms
        add_scan(0, 14'h3FFF, 100);
        add_scan(0, 14'h0000, 100);
        add_scan(0, 14'h0000, 104);
        add_scan(0, 14'h0000, 105);
        // timer started at time zero stays idle, restarts on the next scan
        add_scan(0, 14'h3FFF, 0);
        add_scan(0, 14'h3FFF, 1000);
        add_scan(0, 14'h3FFF, 1005);
        // elapsed time across the 32-bit wrap
        add_scan(7, 14'h3FFE, 32'hFFFF_FFFE);
        add_scan(7, 14'h3FFE, 3);
        // bounce back to agreement clears the timer
        add_scan(7, 14'h3FFF, 10);
        add_scan(7, 14'h3FFE, 12);
        add_scan(7, 14'h3FFF, 20);
        add_scan(7, 14'h3FFF, 24);

        // zero interval still needs a second mismatching scan
        write_interval(16'd0);
        add_scan(3, 14'h2AAA, 50);
        add_scan(3, 14'h2AAA, 50);
        add_scan(3, 14'h1555, 0);
        add_scan(3, 14'h1555, 0);
        add_scan(3, 14'h1555, 1);
        add_scan(3, 14'h1555, 1);

        write_interval(16'hFFFF);
        add_scan(5, 14'h0000, 7);
        add_scan(5, 14'h0000, 65541);
        add_scan(5, 14'h0000, 65542);

        dms = DMS_W'($urandom_range(1, 20));
        write_interval(dms);
        gap_pct   = 8;
        stall_pct = 75;
        add_random_scans(130, dms);

        write_interval(16'hFFFF);
        gap_pct   = 75;
        stall_pct = 8;
        add_random_scans(130, 16'hFFFF);

        write_interval(16'd0);
        gap_pct   = 0;
        stall_pct = 0;
        add_random_scans(130, 16'd0);

        wait_drained();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/kmd_pkg.sv
src/kmd_if.sv
src/kmd_row_pipe.sv
src/kmd_out_fifo.sv
src/key_matrix_debouncer.sv
dv/key_matrix_debouncer_tb.sv
